// ===== design/hvcc_pkg.sv =====
// Package: shared types, constants and conversion factor for the HV capacitor charger control.
`timescale 1ns / 1ps
`default_nettype none
package hvcc_pkg;

	localparam int unsigned ADC_W       = 12;
	localparam int unsigned VOLT_W      = 9;
	localparam int unsigned DUTY_W      = 10;
	localparam int unsigned TARGET_IN_W = 16;
	localparam int unsigned SAMPLE_W    = 16;

	localparam logic [SAMPLE_W-1:0] ADC_FULL = 16'd4095;

	localparam logic [63:0] ADC_REF_MV = 64'd3300;
	localparam logic [63:0] DIV_TOP    = 64'd1080000;
	localparam logic [63:0] DIV_BOT    = 64'd8200;
	localparam logic [63:0] MV_PER_V   = 64'd1000;

	localparam logic [63:0] CONV_NUM = ADC_REF_MV * (DIV_TOP + DIV_BOT);
	localparam logic [63:0] CONV_DEN = 64'd4095 * DIV_BOT * MV_PER_V;

	localparam int unsigned CONV_SHIFT = 32;
	localparam int unsigned CONV_MUL_W = 29;
	localparam int unsigned CONV_PROD_W = ADC_W + CONV_MUL_W;
	localparam logic [CONV_MUL_W-1:0] CONV_MUL =
		CONV_MUL_W'(((CONV_NUM << CONV_SHIFT) + CONV_DEN - 64'd1) / CONV_DEN);

	localparam logic [VOLT_W-1:0] TARGET_MAX   = 9'd345;
	localparam logic [VOLT_W-1:0] OVERVOLT     = 9'd370;
	localparam logic [VOLT_W-1:0] IMBAL_FLOOR  = 9'd80;
	localparam logic [VOLT_W-1:0] IMBAL_DIFF   = 9'd50;
	localparam logic [VOLT_W:0]   REG_MARGIN   = 10'd4;
	localparam logic [VOLT_W:0]   RAMP_MARGIN  = 10'd10;

	localparam logic [DUTY_W-1:0] DUTY_LIMIT    = 10'd1000;
	localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = 10'd300;
	localparam logic [DUTY_W:0]   DUTY_STEP     = 11'd2;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_CLEAR = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_RAMP  = 2'd1,
		MODE_REG   = 2'd2,
		MODE_FAULT = 2'd3
	} mode_t;

	typedef struct packed {
		opcode_t             opcode;
		logic                trip;
		logic                stop;
		logic                above;
		logic                below;
		logic                clear_ok;
		logic [VOLT_W-1:0]   center;
		logic [VOLT_W-1:0]   side;
	} cmd_t;

endpackage
`default_nettype wire

// ===== design/hvcc_if.sv =====
// Interfaces: command and response channels of the HV capacitor charger control.
`timescale 1ns / 1ps
`default_nettype none
interface hvcc_cmd_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] target_voltage;
	logic [15:0] adc_center_sample;
	logic [15:0] adc_side_sample;
	logic        output_allowed;
	logic        sw_enable;
	logic        hw_fault;
	logic        engine_halted;

	modport source (
		output valid, opcode, target_voltage, adc_center_sample, adc_side_sample,
		output output_allowed, sw_enable, hw_fault, engine_halted,
		input  ready
	);
	modport sink (
		input  valid, opcode, target_voltage, adc_center_sample, adc_side_sample,
		input  output_allowed, sw_enable, hw_fault, engine_halted,
		output ready
	);
endinterface

interface hvcc_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] charger_mode;
	logic [9:0] duty_out;
	logic [8:0] center_voltage;
	logic [8:0] side_voltage;
	logic       clear_accepted;

	modport source (
		output valid, charger_mode, duty_out, center_voltage, side_voltage, clear_accepted,
		input  ready
	);
	modport sink (
		input  valid, charger_mode, duty_out, center_voltage, side_voltage, clear_accepted,
		output ready
	);
endinterface
`default_nettype wire

// ===== design/hvcc_front.sv =====
// Front end: accept commands, convert ADC samples to volts and classify the tick.
`timescale 1ns / 1ps
`default_nettype none
module hvcc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	hvcc_cmd_if.sink           cmd,
	output hvcc_pkg::cmd_t     q_data,
	output logic               q_valid,
	input  wire logic          q_ready
);
	import hvcc_pkg::*;

	logic                   valid_s1;
	opcode_t                opcode_s1;
	logic [VOLT_W-1:0]      target_s1;
	logic                   stop_s1;
	logic                   hwf_s1;
	logic                   clear_ok_s1;
	logic [VOLT_W-1:0]      center_s1;
	logic [VOLT_W-1:0]      side_s1;

	logic                   valid_s2;
	cmd_t                   cmd_s2;

	logic                   adv_s1;
	logic                   adv_s2;
	logic [ADC_W-1:0]       center_adc;
	logic [ADC_W-1:0]       side_adc;
	logic [CONV_PROD_W-1:0] center_prod;
	logic [CONV_PROD_W-1:0] side_prod;
	logic [VOLT_W-1:0]      target_clamp;

	logic [VOLT_W-1:0]      hi;
	logic [VOLT_W-1:0]      lo;
	logic [VOLT_W-1:0]      diff;
	cmd_t                   cmd_d;

	assign adv_s2    = !valid_s2 || q_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign cmd.ready = adv_s1;

	// saturate samples and scale to volts
	assign center_adc = (cmd.adc_center_sample > ADC_FULL) ? ADC_W'(ADC_FULL)
		: cmd.adc_center_sample[ADC_W-1:0];
	assign side_adc   = (cmd.adc_side_sample > ADC_FULL) ? ADC_W'(ADC_FULL)
		: cmd.adc_side_sample[ADC_W-1:0];
	assign center_prod = CONV_PROD_W'(center_adc) * CONV_PROD_W'(CONV_MUL);
	assign side_prod   = CONV_PROD_W'(side_adc) * CONV_PROD_W'(CONV_MUL);
	assign target_clamp = (cmd.target_voltage > TARGET_IN_W'(TARGET_MAX)) ? TARGET_MAX
		: cmd.target_voltage[VOLT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && cmd.valid) begin
			opcode_s1   <= opcode_t'(cmd.opcode);
			target_s1   <= target_clamp;
			stop_s1     <= !cmd.output_allowed || !cmd.sw_enable;
			hwf_s1      <= cmd.hw_fault;
			clear_ok_s1 <= cmd.engine_halted && !cmd.sw_enable;
			center_s1   <= center_prod[CONV_SHIFT +: VOLT_W];
			side_s1     <= side_prod[CONV_SHIFT +: VOLT_W];
		end
	end

	always_comb begin
		hi   = (center_s1 > side_s1) ? center_s1 : side_s1;
		lo   = (center_s1 < side_s1) ? center_s1 : side_s1;
		diff = hi - lo;
		cmd_d.opcode   = opcode_s1;
		cmd_d.trip     = hwf_s1 || (hi >= OVERVOLT) || ((hi > IMBAL_FLOOR) && (diff > IMBAL_DIFF));
		cmd_d.stop     = stop_s1;
		cmd_d.above    = {1'b0, hi} >= ({1'b0, target_s1} + REG_MARGIN);
		cmd_d.below    = ({1'b0, lo} + RAMP_MARGIN) < {1'b0, target_s1};
		cmd_d.clear_ok = clear_ok_s1;
		cmd_d.center   = center_s1;
		cmd_d.side     = side_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			cmd_s2 <= cmd_d;
		end
	end

	assign q_valid = valid_s2;
	assign q_data  = cmd_s2;
endmodule
`default_nettype wire

// ===== design/hvcc_queue.sv =====
// Queue: short FIFO of classified commands between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module hvcc_queue #(
	parameter int unsigned DEPTH = hvcc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  hvcc_pkg::cmd_t     push_data,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output hvcc_pkg::cmd_t     pop_data
);
	import hvcc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_FULL;
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

// ===== design/hvcc_back.sv =====
// Back end: charger state update, duty control and response register.
`timescale 1ns / 1ps
`default_nettype none
module hvcc_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [hvcc_pkg::DUTY_W-1:0] cfg_wdata,
	input  wire logic                    pop_valid,
	output logic                         pop_ready,
	input  hvcc_pkg::cmd_t               pop_data,
	hvcc_rsp_if.source                   rsp
);
	import hvcc_pkg::*;

	logic [DUTY_W-1:0] max_duty_q;
	mode_t             mode_q;
	logic [DUTY_W-1:0] duty_q;
	logic              fault_q;
	logic [VOLT_W-1:0] center_q;
	logic [VOLT_W-1:0] side_q;
	logic              accepted_q;
	logic              rsp_valid_q;

	mode_t             mode_d;
	logic [DUTY_W-1:0] duty_d;
	logic              fault_d;
	logic [VOLT_W-1:0] center_d;
	logic [VOLT_W-1:0] side_d;
	logic              accepted_d;
	logic [DUTY_W-1:0] ceil_duty;
	logic              pop;

	assign pop_ready = !rsp_valid_q || rsp.ready;
	assign pop       = pop_valid && pop_ready;
	assign ceil_duty = (max_duty_q > DUTY_LIMIT) ? DUTY_LIMIT : max_duty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_duty_q <= MAX_DUTY_RST;
		end else if (cfg_we) begin
			max_duty_q <= cfg_wdata;
		end
	end

	// next state
	always_comb begin
		mode_d     = mode_q;
		duty_d     = duty_q;
		fault_d    = fault_q;
		center_d   = center_q;
		side_d     = side_q;
		accepted_d = 1'b0;
		case (pop_data.opcode)
			OP_TICK: begin
				center_d = pop_data.center;
				side_d   = pop_data.side;
				if (pop_data.trip) begin
					fault_d = 1'b1;
					mode_d  = MODE_FAULT;
					duty_d  = '0;
				end else if (fault_q) begin
					mode_d = MODE_FAULT;
					duty_d = '0;
				end else if (pop_data.stop) begin
					mode_d = MODE_OFF;
					duty_d = '0;
				end else if (pop_data.above) begin
					mode_d = MODE_REG;
					duty_d = '0;
				end else if (pop_data.below) begin
					mode_d = MODE_RAMP;
					if (({1'b0, duty_q} + DUTY_STEP) <= {1'b0, ceil_duty}) begin
						duty_d = duty_q + DUTY_W'(DUTY_STEP);
					end
				end else begin
					mode_d = MODE_REG;
					if (duty_q != '0) begin
						duty_d = duty_q - 1'b1;
					end
				end
			end
			OP_CLEAR: begin
				if (pop_data.clear_ok) begin
					fault_d    = 1'b0;
					mode_d     = MODE_OFF;
					duty_d     = '0;
					accepted_d = 1'b1;
				end
			end
			default: begin
				accepted_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_OFF;
			duty_q      <= '0;
			fault_q     <= 1'b0;
			center_q    <= '0;
			side_q      <= '0;
			accepted_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q     <= mode_d;
				duty_q     <= duty_d;
				fault_q    <= fault_d;
				center_q   <= center_d;
				side_q     <= side_d;
				accepted_q <= accepted_d;
			end
			if (pop_ready) begin
				rsp_valid_q <= pop_valid;
			end
		end
	end

	// outputs
	always_comb begin
		rsp.valid          = rsp_valid_q;
		rsp.charger_mode   = mode_q;
		rsp.duty_out       = duty_q;
		rsp.center_voltage = center_q;
		rsp.side_voltage   = side_q;
		rsp.clear_accepted = accepted_q;
	end
endmodule
`default_nettype wire

// ===== design/hv_capacitor_charger_control.sv =====
// Top level: HV capacitor charger control, front end, queue and back end.
//
//   channel  dir  handshake         payload
//   cmd      in   valid / ready     opcode, target, two ADC samples, four flags
//   rsp      out  valid / ready     mode, duty, two tap voltages, clear flag
//   cfg      in   cfg_we            max_duty (10 bits)
//
// One command per cycle sustained while rsp is not stalled; a response is registered through both
// front stages, the queue entry and the back register after its transfer.
// arst_n clears all control state, the charger state and sets max_duty to 300.
// A stalled rsp holds the back end; the queue then fills and cmd.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module hv_capacitor_charger_control #(
	parameter int unsigned QUEUE_DEPTH = hvcc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	hvcc_cmd_if.sink                         cmd,
	hvcc_rsp_if.source                       rsp,
	input  wire logic                        cfg_we,
	input  wire logic [hvcc_pkg::DUTY_W-1:0] cfg_wdata
);
	import hvcc_pkg::*;

	cmd_t push_data;
	logic push_valid;
	logic push_ready;
	cmd_t pop_data;
	logic pop_valid;
	logic pop_ready;

	hvcc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_data  (push_data),
		.q_valid (push_valid),
		.q_ready (push_ready)
	);

	hvcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	hvcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp       (rsp)
	);
endmodule
`default_nettype wire

// ===== design/hvcc_checker.sv =====
// Checker: port-level assertions for the HV capacitor charger control, with bind.
`timescale 1ns / 1ps
`default_nettype none
module hvcc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [1:0] rsp_mode,
	input wire logic [9:0] rsp_duty,
	input wire logic [8:0] rsp_center,
	input wire logic [8:0] rsp_side,
	input wire logic       rsp_clear
);
	import hvcc_pkg::*;

	logic rsp_xfer;
	assign rsp_xfer = rsp_valid && rsp_ready;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
			&& $stable({rsp_mode, rsp_duty, rsp_center, rsp_side, rsp_clear}))
		else $error("response dropped or changed while stalled");

	a_fault_duty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_mode == MODE_FAULT) |-> rsp_duty == '0)
		else $error("nonzero duty in fault mode");

	a_clear_off: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_clear |-> (rsp_mode == MODE_OFF) && (rsp_duty == '0))
		else $error("accepted clear without off state");

	a_ramp_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_xfer ##1 rsp_xfer |-> rsp_duty <= $past(rsp_duty) + 2)
		else $error("duty rose by more than one ramp step");
endmodule

bind hv_capacitor_charger_control hvcc_checker u_hvcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_mode   (rsp.charger_mode),
	.rsp_duty   (rsp.duty_out),
	.rsp_center (rsp.center_voltage),
	.rsp_side   (rsp.side_voltage),
	.rsp_clear  (rsp.clear_accepted)
);
`default_nettype wire
